### hw/rtl/rtfp_pkg.sv
// rtfp_pkg: shared types, codes and helpers of the radar tlv frame parser
// no dependencies; imported by the queue, front, back and top modules of the block
package rtfp_pkg;

    // fixed positions inside the frame header and tlv header
    localparam int COUNT_OFFSET = 24;
    localparam int WORD_BYTES   = 4;

    // depth of the queues between the parts
    localparam int QUEUE_DEPTH = 2;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_MAGIC   = 2'd0,
        REG_PTYPE   = 2'd1,
        REG_TIMEOUT = 2'd2
    } reg_idx_t;

    // parser phase
    typedef enum logic [2:0] {
        PH_MAGIC0    = 3'd0,
        PH_MAGIC1    = 3'd1,
        PH_MAGIC2    = 3'd2,
        PH_MAGIC3    = 3'd3,
        PH_FRAME_HDR = 3'd4,
        PH_TLV_HDR   = 3'd5,
        PH_PAYLOAD   = 3'd6
    } phase_t;

    // classified item from the front part
    typedef struct packed {
        logic        point_valid;
        logic [4:0]  point_index;
        logic [3:0]  byte_offset;
        logic [7:0]  point_byte;
        logic        update_valid;
        logic [5:0]  target_count;
        logic [31:0] now_ms;
    } mid_item_t;

    // finished result item
    typedef struct packed {
        logic        point_valid;
        logic [4:0]  point_index;
        logic [3:0]  byte_offset;
        logic [7:0]  point_byte;
        logic        update_valid;
        logic [5:0]  target_count;
        logic [31:0] update_time;
        logic        link_alive;
    } out_item_t;

    // place byte b at little-endian byte position pos of word w
    function automatic logic [31:0] put_byte(input logic [31:0] w, input logic [1:0] pos,
                                             input logic [7:0] b);
        logic [31:0] r;
        r = w;
        r[{pos, 3'b000} +: 8] = b;
        return r;
    endfunction

endpackage

### hw/rtl/rtfp_queue.sv
// rtfp_queue: small first-in first-out queue between the parts
// depends on rtfp_pkg for the depth
module rtfp_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);
    import rtfp_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full    = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

endmodule

### hw/rtl/rtfp_front.sv
// rtfp_front: byte parser; hunts the magic word, walks frame and tlv headers
// and classifies each byte into a point byte and/or an update; uses rtfp_pkg
module rtfp_front #(
    parameter int FRAME_HEADER_BYTES = 32,
    parameter int TLV_HEADER_BYTES   = 8,
    parameter int PAYLOAD_MAX        = 1024,
    parameter int POINT_BYTES        = 16,
    parameter int TARGET_LIMIT       = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  logic [7:0]          rx_byte,
    input  logic [31:0]         now_ms,
    input  logic [31:0]         magic_word,
    input  logic [31:0]         points_type,
    output rtfp_pkg::mid_item_t item
);
    import rtfp_pkg::*;

    localparam int HC_MAX  = (FRAME_HEADER_BYTES > TLV_HEADER_BYTES) ?
                             FRAME_HEADER_BYTES : TLV_HEADER_BYTES;
    localparam int HC_W    = $clog2(HC_MAX + 1);
    localparam int LEN_W   = $clog2(PAYLOAD_MAX + 1);
    localparam int SHIFT   = LEN_W + $clog2(POINT_BYTES);
    localparam int RECIP   = ((1 << SHIFT) + POINT_BYTES - 1) / POINT_BYTES;
    localparam int MUL_W   = 2 * LEN_W + 1;
    localparam int CNT_W   = $clog2(TARGET_LIMIT + 1);
    localparam int OFF_W   = $clog2(POINT_BYTES + 1);

    phase_t             phase_reg, phase_next;
    logic [HC_W-1:0]    hc_reg, hc_next;
    logic [31:0]        tlvs_reg, tlvs_next;
    logic [31:0]        type_reg, type_next;
    logic [31:0]        len_reg, len_next;
    logic [LEN_W-1:0]   pay_cnt_reg, pay_cnt_next;
    logic [CNT_W-1:0]   pt_idx_reg, pt_idx_next;
    logic [OFF_W-1:0]   pt_off_reg, pt_off_next;
    logic [CNT_W-1:0]   pt_cnt_reg, pt_cnt_next;

    logic [HC_W-1:0]    hc_inc;
    logic [7:0]         magic_want;
    logic               magic_hit;
    logic               frame_last, tlv_last, pay_last, len_ok, kept, is_points;
    logic [31:0]        tlvs_new, type_new, len_new, tlvs_dec;
    logic [LEN_W-1:0]   pay_inc;
    logic [MUL_W-1:0]   quot_prod, quot;
    logic [CNT_W-1:0]   quot_sat;

    assign hc_inc     = hc_reg + 1'b1;
    assign magic_want = 8'(magic_word >> {phase_reg[1:0], 3'b000});
    assign magic_hit  = (rx_byte == magic_want);
    assign frame_last = (hc_inc == HC_W'(FRAME_HEADER_BYTES));
    assign tlv_last   = (hc_inc == HC_W'(TLV_HEADER_BYTES));
    assign tlvs_dec   = tlvs_reg - 32'd1;
    assign pay_inc    = pay_cnt_reg + 1'b1;
    assign pay_last   = (pay_inc >= len_reg[LEN_W-1:0]);
    assign is_points  = (type_reg == points_type);
    assign kept       = (pt_idx_reg < pt_cnt_reg);

    // tlv count bytes of the frame header, little-endian
    always_comb
    begin
        tlvs_new = tlvs_reg;
        if (hc_reg >= HC_W'(COUNT_OFFSET) && hc_reg < HC_W'(COUNT_OFFSET + WORD_BYTES))
        begin
            tlvs_new = put_byte(tlvs_reg, 2'(hc_reg - HC_W'(COUNT_OFFSET)), rx_byte);
        end
    end

    // type and length words of the tlv header
    always_comb
    begin
        type_new = type_reg;
        len_new  = len_reg;
        if (hc_reg < HC_W'(WORD_BYTES))
        begin
            type_new = put_byte(type_reg, 2'(hc_reg), rx_byte);
        end
        else if (hc_reg < HC_W'(2 * WORD_BYTES))
        begin
            len_new = put_byte(len_reg, 2'(hc_reg - HC_W'(WORD_BYTES)), rx_byte);
        end
    end

    assign len_ok = (len_new != 32'd0) && (len_new <= 32'(PAYLOAD_MAX));

    // whole points in the payload by reciprocal multiply, exact for LEN_W-bit lengths
    assign quot_prod = MUL_W'(len_new[LEN_W-1:0]) * MUL_W'(RECIP);
    assign quot      = quot_prod >> SHIFT;
    assign quot_sat  = (quot > MUL_W'(TARGET_LIMIT)) ? CNT_W'(TARGET_LIMIT) : CNT_W'(quot);

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_MAGIC0:    phase_next = magic_hit ? PH_MAGIC1 : PH_MAGIC0;
            PH_MAGIC1:    phase_next = magic_hit ? PH_MAGIC2 : PH_MAGIC0;
            PH_MAGIC2:    phase_next = magic_hit ? PH_MAGIC3 : PH_MAGIC0;
            PH_MAGIC3:    phase_next = magic_hit ? PH_FRAME_HDR : PH_MAGIC0;
            PH_FRAME_HDR:
            begin
                if (frame_last)
                begin
                    phase_next = (tlvs_new != 32'd0) ? PH_TLV_HDR : PH_MAGIC0;
                end
            end
            PH_TLV_HDR:
            begin
                if (tlv_last)
                begin
                    if (len_ok)
                    begin
                        phase_next = PH_PAYLOAD;
                    end
                    else
                    begin
                        phase_next = (tlvs_dec != 32'd0) ? PH_TLV_HDR : PH_MAGIC0;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                if (pay_last)
                begin
                    phase_next = (tlvs_dec != 32'd0) ? PH_TLV_HDR : PH_MAGIC0;
                end
            end
            default:      phase_next = PH_MAGIC0;
        endcase
    end

    // datapath and classified item
    always_comb
    begin
        hc_next      = hc_reg;
        tlvs_next    = tlvs_reg;
        type_next    = type_reg;
        len_next     = len_reg;
        pay_cnt_next = pay_cnt_reg;
        pt_idx_next  = pt_idx_reg;
        pt_off_next  = pt_off_reg;
        pt_cnt_next  = pt_cnt_reg;
        item         = '0;
        item.now_ms  = now_ms;
        case (phase_reg)
            PH_MAGIC0, PH_MAGIC1, PH_MAGIC2, PH_MAGIC3:
            begin
                if (magic_hit)
                begin
                    hc_next = '0;
                end
            end
            PH_FRAME_HDR:
            begin
                tlvs_next = tlvs_new;
                hc_next   = frame_last ? '0 : hc_inc;
            end
            PH_TLV_HDR:
            begin
                type_next = type_new;
                len_next  = len_new;
                hc_next   = tlv_last ? '0 : hc_inc;
                if (tlv_last)
                begin
                    pay_cnt_next = '0;
                    pt_idx_next  = '0;
                    pt_off_next  = '0;
                    pt_cnt_next  = quot_sat;
                    if (!len_ok)
                    begin
                        tlvs_next = tlvs_dec;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                pay_cnt_next = pay_inc;
                if (kept)
                begin
                    if (is_points)
                    begin
                        item.point_valid = 1'b1;
                        item.point_index = 5'(pt_idx_reg);
                        item.byte_offset = 4'(pt_off_reg);
                        item.point_byte  = rx_byte;
                    end
                    // walk target index and record offset without dividing
                    if (pt_off_reg == OFF_W'(POINT_BYTES - 1))
                    begin
                        pt_off_next = '0;
                        pt_idx_next = pt_idx_reg + 1'b1;
                    end
                    else
                    begin
                        pt_off_next = pt_off_reg + 1'b1;
                    end
                end
                if (pay_last)
                begin
                    tlvs_next = tlvs_dec;
                    hc_next   = '0;
                    if (is_points)
                    begin
                        item.update_valid = 1'b1;
                        item.target_count = 6'(pt_cnt_reg);
                    end
                end
            end
            default:
            begin
                hc_next = hc_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_MAGIC0;
            hc_reg      <= '0;
            tlvs_reg    <= '0;
            type_reg    <= '0;
            len_reg     <= '0;
            pay_cnt_reg <= '0;
            pt_idx_reg  <= '0;
            pt_off_reg  <= '0;
            pt_cnt_reg  <= '0;
        end
        else if (take)
        begin
            phase_reg   <= phase_next;
            hc_reg      <= hc_next;
            tlvs_reg    <= tlvs_next;
            type_reg    <= type_next;
            len_reg     <= len_next;
            pay_cnt_reg <= pay_cnt_next;
            pt_idx_reg  <= pt_idx_next;
            pt_off_reg  <= pt_off_next;
            pt_cnt_reg  <= pt_cnt_next;
        end
    end

endmodule

### hw/rtl/rtfp_back.sv
// rtfp_back: keeps the last update tick and works out update_time and link_alive
// depends on rtfp_pkg for the item types
module rtfp_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  rtfp_pkg::mid_item_t mid,
    input  logic [31:0]         alive_timeout,
    output rtfp_pkg::out_item_t res
);
    import rtfp_pkg::*;

    logic [31:0] last_upd_reg, last_upd_next;
    logic [31:0] age;

    assign last_upd_next = mid.update_valid ? mid.now_ms : last_upd_reg;
    // wrapping age of the latest update
    assign age           = mid.now_ms - last_upd_next;

    always_comb
    begin
        res.point_valid  = mid.point_valid;
        res.point_index  = mid.point_index;
        res.byte_offset  = mid.byte_offset;
        res.point_byte   = mid.point_byte;
        res.update_valid = mid.update_valid;
        res.target_count = mid.target_count;
        res.update_time  = last_upd_next;
        res.link_alive   = (last_upd_next != 32'd0) && (age < alive_timeout);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_upd_reg <= '0;
        end
        else if (take)
        begin
            last_upd_reg <= last_upd_next;
        end
    end

endmodule

### hw/rtl/radar_tlv_frame_parser.sv
// radar_tlv_frame_parser: top level, apb registers, front parser, queues, back part
// path: a taken item is written into the mid queue, then passes the back part into the output queue
// throughput: one item per cycle while the input side is not full, as the front parses one byte per taken item
// reset (rst_n low, async): hunting first magic byte, queues empty, registers at defaults
// depends on rtfp_pkg, rtfp_queue, rtfp_front, rtfp_back
module radar_tlv_frame_parser #(
    parameter int FRAME_HEADER_BYTES = 32,
    parameter int TLV_HEADER_BYTES   = 8,
    parameter int PAYLOAD_MAX        = 1024,
    parameter int POINT_BYTES        = 16,
    parameter int TARGET_LIMIT       = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    // input item queue side
    input  logic        push,
    output logic        full,
    input  logic [7:0]  rx_byte,
    input  logic [31:0] now_ms,
    // result queue side
    output logic        empty,
    input  logic        pop,
    output logic        point_valid,
    output logic [4:0]  point_index,
    output logic [3:0]  byte_offset,
    output logic [7:0]  point_byte,
    output logic        update_valid,
    output logic [5:0]  target_count,
    output logic [31:0] update_time,
    output logic        link_alive,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rtfp_pkg::*;

    localparam int MID_W = $bits(mid_item_t);
    localparam int OUT_W = $bits(out_item_t);

    // configuration registers
    logic [31:0] magic_reg, ptype_reg, timeout_reg;
    logic        cfg_wr;
    reg_idx_t    cfg_idx;

    // front to back queue
    mid_item_t   front_item, mid_head;
    logic [MID_W-1:0] mid_head_bits;
    logic        mid_full, mid_empty, item_take;

    // back to result queue
    out_item_t   back_item, res_head;
    logic [OUT_W-1:0] res_head_bits;
    logic        out_full, back_take;

    // ---------------------------------------------------------------
    // apb register file: no wait states, word addressed by paddr[3:2]
    // ---------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        case (cfg_idx)
            REG_MAGIC:   prdata = magic_reg;
            REG_PTYPE:   prdata = ptype_reg;
            REG_TIMEOUT: prdata = timeout_reg;
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg   <= 32'h0304_0102;
            ptype_reg   <= 32'd1;
            timeout_reg <= 32'd1000;
        end
        else if (cfg_wr)
        begin
            // writes to unmapped addresses are dropped
            case (cfg_idx)
                REG_MAGIC:   magic_reg   <= pwdata;
                REG_PTYPE:   ptype_reg   <= pwdata;
                REG_TIMEOUT: timeout_reg <= pwdata;
                default:     magic_reg   <= magic_reg;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // front: parses one byte per accepted item, always yields one item
    // ---------------------------------------------------------------
    assign full      = mid_full;
    assign item_take = push && !mid_full;

    rtfp_front #(
        .FRAME_HEADER_BYTES (FRAME_HEADER_BYTES),
        .TLV_HEADER_BYTES   (TLV_HEADER_BYTES),
        .PAYLOAD_MAX        (PAYLOAD_MAX),
        .POINT_BYTES        (POINT_BYTES),
        .TARGET_LIMIT       (TARGET_LIMIT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (item_take),
        .rx_byte     (rx_byte),
        .now_ms      (now_ms),
        .magic_word  (magic_reg),
        .points_type (ptype_reg),
        .item        (front_item)
    );

    // short queue so the parser keeps going while the back side stalls
    rtfp_queue #(
        .WIDTH (MID_W)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (item_take),
        .wdata (front_item),
        .full  (mid_full),
        .pop   (back_take),
        .rdata (mid_head_bits),
        .empty (mid_empty)
    );

    assign mid_head = mid_head_bits;

    // ---------------------------------------------------------------
    // back: link state, moves one item per cycle, while one waits and there is room, into the result queue
    // ---------------------------------------------------------------
    assign back_take = !mid_empty && !out_full;

    rtfp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (back_take),
        .mid           (mid_head),
        .alive_timeout (timeout_reg),
        .res           (back_item)
    );

    // result queue doubles as the output skid stage
    rtfp_queue #(
        .WIDTH (OUT_W)
    ) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (back_take),
        .wdata (back_item),
        .full  (out_full),
        .pop   (pop),
        .rdata (res_head_bits),
        .empty (empty)
    );

    assign res_head     = res_head_bits;
    assign point_valid  = res_head.point_valid;
    assign point_index  = res_head.point_index;
    assign byte_offset  = res_head.byte_offset;
    assign point_byte   = res_head.point_byte;
    assign update_valid = res_head.update_valid;
    assign target_count = res_head.target_count;
    assign update_time  = res_head.update_time;
    assign link_alive   = res_head.link_alive;

endmodule

### hw/rtl/rtfp_checker.sv
// rtfp_checker: port-level checks of the radar tlv frame parser, bound to the top
// depends only on the top level's ports
module rtfp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        push,
    input logic        full,
    input logic [7:0]  rx_byte,
    input logic [31:0] now_ms,
    input logic        empty,
    input logic        pop,
    input logic        point_valid,
    input logic [4:0]  point_index,
    input logic [3:0]  byte_offset,
    input logic [7:0]  point_byte,
    input logic        update_valid,
    input logic [5:0]  target_count,
    input logic [31:0] update_time,
    input logic        link_alive
);

    // non-point items carry zeroed point fields
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !point_valid) |-> (point_index == 5'd0 && byte_offset == 4'd0
                                      && point_byte == 8'd0))
        else $error("point fields set on a non-point item");

    // target count only on an update
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !update_valid) |-> (target_count == 6'd0))
        else $error("target count set without update");

    // alive needs a recorded nonzero update tick
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && link_alive) |-> (update_time != 32'd0))
        else $error("link alive with no update");

    // a waiting result holds until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(point_byte) && $stable(update_time)))
        else $error("waiting result changed");

endmodule

bind radar_tlv_frame_parser rtfp_checker u_rtfp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .rx_byte      (rx_byte),
    .now_ms       (now_ms),
    .empty        (empty),
    .pop          (pop),
    .point_valid  (point_valid),
    .point_index  (point_index),
    .byte_offset  (byte_offset),
    .point_byte   (point_byte),
    .update_valid (update_valid),
    .target_count (target_count),
    .update_time  (update_time),
    .link_alive   (link_alive)
);

### sim/tb_radar_tlv_frame_parser.sv
`timescale 1ns / 100ps
// tb_radar_tlv_frame_parser: self-checking bench for the radar tlv frame parser
// feeds serial bytes with ms ticks, predicts each result item and checks it in order
// depends on rtfp_pkg and radar_tlv_frame_parser
module tb_radar_tlv_frame_parser;
    import rtfp_pkg::*;

    // block sizes, kept at the defaults of the top level
    localparam int FRAME_HDR_BYTES = 32;
    localparam int TLV_HDR_BYTES   = 8;
    localparam int PAYLOAD_MAX     = 1024;
    localparam int POINT_BYTES     = 16;
    localparam int TARGET_LIMIT    = 32;

    // a result passes the mid queue and the back part before it shows; leave some margin
    localparam int SETTLE_CYCLES   = 8;
    localparam int MAX_REPORTS     = 10;
    localparam int HOLD_CYCLES     = 200;
    localparam int ITEMS_PER_SETUP = 150;

    // register index with no register behind it
    localparam logic [1:0] REG_UNUSED = 2'd3;

    // reset values of the registers
    localparam logic [31:0] MAGIC_DEFAULT   = 32'h0304_0102;
    localparam logic [31:0] PTYPE_DEFAULT   = 32'd1;
    localparam logic [31:0] TIMEOUT_DEFAULT = 32'd1000;

    logic        clk;
    logic        rst_n   = 1'b0;
    logic        push    = 1'b0;
    logic        full;
    logic [7:0]  rx_byte = '0;
    logic [31:0] now_ms  = '0;
    logic        empty;
    logic        pop     = 1'b0;
    logic        point_valid;
    logic [4:0]  point_index;
    logic [3:0]  byte_offset;
    logic [7:0]  point_byte;
    logic        update_valid;
    logic [5:0]  target_count;
    logic [31:0] update_time;
    logic        link_alive;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [3:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    radar_tlv_frame_parser #(
        .FRAME_HEADER_BYTES (FRAME_HDR_BYTES),
        .TLV_HEADER_BYTES   (TLV_HDR_BYTES),
        .PAYLOAD_MAX        (PAYLOAD_MAX),
        .POINT_BYTES        (POINT_BYTES),
        .TARGET_LIMIT       (TARGET_LIMIT)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .rx_byte      (rx_byte),
        .now_ms       (now_ms),
        .empty        (empty),
        .pop          (pop),
        .point_valid  (point_valid),
        .point_index  (point_index),
        .byte_offset  (byte_offset),
        .point_byte   (point_byte),
        .update_valid (update_valid),
        .target_count (target_count),
        .update_time  (update_time),
        .link_alive   (link_alive),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // 4 ns clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // ------------------------------------------------------------------
    // parser shadow: registers and state, updated once per accepted item
    // ------------------------------------------------------------------
    logic [31:0] cfg_magic       = MAGIC_DEFAULT;
    logic [31:0] cfg_points_type = PTYPE_DEFAULT;
    logic [31:0] cfg_timeout     = TIMEOUT_DEFAULT;

    phase_t      ps_phase       = PH_MAGIC0;
    int unsigned ps_hdr_cnt     = 0;
    logic [31:0] ps_tlvs_left   = '0;
    logic [31:0] ps_tlv_type    = '0;
    logic [31:0] ps_tlv_len     = '0;
    int unsigned ps_pay_cnt     = 0;
    int unsigned ps_keep_bytes  = 0;
    logic [31:0] ps_last_update = '0;

    // results predicted but not yet popped, oldest first
    out_item_t   pending_results[$];

    // bookkeeping
    int unsigned items_sent      = 0;
    int unsigned results_checked = 0;
    int unsigned updates_seen    = 0;
    int unsigned settings_used   = 0;
    int unsigned mismatches      = 0;

    // sender pacing
    bit          idle_on    = 1'b1;
    int unsigned burst_left = 0;
    logic [31:0] tick_ms    = '0;

    // bytes of the frame being built
    bit [7:0]    frame_q[$];

    // receiver hold-off request, toggled by the tests
    bit          hold_req = 1'b0;

    function automatic logic [7:0] magic_byte(input int unsigned k);
        return cfg_magic[8*k +: 8];
    endfunction

    // one tlv done: either the next tlv header or back to hunting
    function automatic void end_tlv();
        ps_tlvs_left = ps_tlvs_left - 32'd1;
        ps_hdr_cnt   = 0;
        ps_phase     = (ps_tlvs_left == 0) ? PH_MAGIC0 : PH_TLV_HDR;
    endfunction

    // one parser step: advances the shadow state and returns the result item
    function automatic out_item_t parse_byte(input logic [7:0] b, input logic [31:0] t);
        out_item_t   r;
        logic [31:0] age;
        bit          is_points;
        int unsigned npts;
        r = '0;
        case (ps_phase)
            PH_MAGIC0, PH_MAGIC1, PH_MAGIC2, PH_MAGIC3:
            begin
                // a mismatch drops back to the first byte without a second look
                if (b == magic_byte(ps_phase))
                begin
                    ps_phase   = phase_t'(ps_phase + 3'd1);
                    ps_hdr_cnt = 0;
                end
                else
                begin
                    ps_phase = PH_MAGIC0;
                end
            end
            PH_FRAME_HDR:
            begin
                // tlv count, little-endian; the frame length field is not used
                if (ps_hdr_cnt >= COUNT_OFFSET && ps_hdr_cnt < COUNT_OFFSET + WORD_BYTES)
                    ps_tlvs_left[(ps_hdr_cnt - COUNT_OFFSET)*8 +: 8] = b;
                ps_hdr_cnt++;
                if (ps_hdr_cnt >= FRAME_HDR_BYTES)
                begin
                    ps_hdr_cnt = 0;
                    ps_phase   = (ps_tlvs_left > 0) ? PH_TLV_HDR : PH_MAGIC0;
                end
            end
            PH_TLV_HDR:
            begin
                if (ps_hdr_cnt < WORD_BYTES)
                    ps_tlv_type[ps_hdr_cnt*8 +: 8] = b;
                else if (ps_hdr_cnt < 2*WORD_BYTES)
                    ps_tlv_len[(ps_hdr_cnt - WORD_BYTES)*8 +: 8] = b;
                ps_hdr_cnt++;
                if (ps_hdr_cnt >= TLV_HDR_BYTES)
                begin
                    ps_hdr_cnt = 0;
                    ps_pay_cnt = 0;
                    if (ps_tlv_len > 0 && ps_tlv_len <= PAYLOAD_MAX)
                    begin
                        npts = ps_tlv_len / POINT_BYTES;
                        if (npts > TARGET_LIMIT)
                            npts = TARGET_LIMIT;
                        ps_keep_bytes = npts * POINT_BYTES;
                        ps_phase      = PH_PAYLOAD;
                    end
                    else
                    begin
                        // bad length: skipped, payload not consumed
                        end_tlv();
                    end
                end
            end
            PH_PAYLOAD:
            begin
                is_points = (ps_tlv_type == cfg_points_type);
                if (is_points && ps_pay_cnt < ps_keep_bytes)
                begin
                    r.point_valid = 1'b1;
                    r.point_index = 5'(ps_pay_cnt / POINT_BYTES);
                    r.byte_offset = 4'(ps_pay_cnt % POINT_BYTES);
                    r.point_byte  = b;
                end
                ps_pay_cnt++;
                if (ps_pay_cnt >= ps_tlv_len)
                begin
                    if (is_points)
                    begin
                        r.update_valid = 1'b1;
                        r.target_count = 6'(ps_keep_bytes / POINT_BYTES);
                        ps_last_update = t;
                        updates_seen++;
                    end
                    end_tlv();
                end
            end
            default:
            begin
                ps_phase = PH_MAGIC0;
            end
        endcase
        // link age with wrapping subtraction; a zero tick reads as never updated
        age           = t - ps_last_update;
        r.update_time = ps_last_update;
        r.link_alive  = (ps_last_update != 0) && (age < cfg_timeout);
        return r;
    endfunction

    function automatic void apply_config(input logic [3:0] addr, input logic [31:0] data);
        case (addr[3:2])
            REG_MAGIC:   cfg_magic       = data;
            REG_PTYPE:   cfg_points_type = data;
            REG_TIMEOUT: cfg_timeout     = data;
            default:     ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // failure reporting and result checking
    // ------------------------------------------------------------------
    task automatic note_failure(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
            note_failure($sformatf("result %0d %s expected %0h got %0h",
                                   results_checked, name, want, got));
    endtask

    task automatic check_result();
        out_item_t want;
        if (pending_results.size() == 0)
        begin
            note_failure($sformatf("result with nothing pending, point_byte %0h update_time %0h",
                                   point_byte, update_time));
            return;
        end
        want = pending_results.pop_front();
        check_field("point_valid",  want.point_valid,  point_valid);
        check_field("point_index",  want.point_index,  point_index);
        check_field("byte_offset",  want.byte_offset,  byte_offset);
        check_field("point_byte",   want.point_byte,   point_byte);
        check_field("update_valid", want.update_valid, update_valid);
        check_field("target_count", want.target_count, target_count);
        check_field("update_time",  want.update_time,  update_time);
        check_field("link_alive",   want.link_alive,   link_alive);
        results_checked++;
    endtask

    // ------------------------------------------------------------------
    // receiver: checks each popped result, stalls on a rotating pattern
    // and on request holds off for a long stretch so the block fills up
    // ------------------------------------------------------------------
    bit [15:0]   pop_pattern = 16'hFFFF;
    int unsigned pattern_age = 0;
    int unsigned hold_left   = 0;
    bit          hold_ack    = 1'b0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pop && !empty)
                check_result();
            if (hold_req != hold_ack)
            begin
                hold_ack  = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
            begin
                // fresh pattern now and then: no stalls, light, heavy or random
                if (pattern_age == 0)
                begin
                    case ($urandom_range(0, 3))
                        0:       pop_pattern = 16'hFFFF;
                        1:       pop_pattern = 16'($urandom);
                        2:       pop_pattern = 16'($urandom | $urandom);
                        default: pop_pattern = 16'($urandom & $urandom);
                    endcase
                    if (pop_pattern == 0)
                        pop_pattern = 16'h0001;
                    pattern_age = $urandom_range(16, 96);
                end
                pattern_age--;
                pop <= pop_pattern[0];
                pop_pattern = {pop_pattern[0], pop_pattern[15:1]};
            end
        end
    end

    // ------------------------------------------------------------------
    // sender side
    // ------------------------------------------------------------------

    // offer one byte until taken, predict its result, then maybe pause
    task automatic send_item(input logic [7:0] b, input logic [31:0] t);
        int unsigned gap;
        push    <= 1'b1;
        rx_byte <= b;
        now_ms  <= t;
        @(posedge clk);
        while (full)
            @(posedge clk);
        pending_results.push_back(parse_byte(b, t));
        items_sent++;
        if (idle_on)
        begin
            if (burst_left > 0)
            begin
                burst_left--;
            end
            else
            begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0)
                begin
                    push <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    endtask

    // stop offering, let every pending result come out, then settle
    task automatic wait_drain();
        push <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // tick mostly creeps forward, sometimes jumps or lands near the alive edge
    task automatic advance_tick();
        case ($urandom_range(0, 63))
            0:       tick_ms = $urandom;
            1:       tick_ms = ps_last_update + cfg_timeout - 32'($urandom_range(0, 2));
            default: tick_ms = tick_ms + 32'($urandom_range(0, 3));
        endcase
    endtask

    // send the built frame; optionally the last byte carries tick zero
    task automatic send_bytes(input bit zero_last);
        bit [7:0] bytes[$];
        bytes = frame_q;
        frame_q.delete();
        foreach (bytes[i])
        begin
            advance_tick();
            if (zero_last && i == bytes.size() - 1)
                tick_ms = '0;
            send_item(bytes[i], tick_ms);
        end
    endtask

    task automatic add_word(input logic [31:0] w);
        for (int k = 0; k < 4; k++)
            frame_q.push_back(w[8*k +: 8]);
    endtask

    // magic word, then header with the tlv count at its little-endian slot
    task automatic start_frame(input logic [31:0] tlv_count);
        add_word(cfg_magic);
        repeat (COUNT_OFFSET) frame_q.push_back(8'($urandom));
        add_word(tlv_count);
        repeat (FRAME_HDR_BYTES - COUNT_OFFSET - WORD_BYTES) frame_q.push_back(8'($urandom));
    endtask

    // tlv header and, for a usable length, its payload
    task automatic add_tlv(input logic [31:0] tlv_type, input logic [31:0] tlv_len);
        add_word(tlv_type);
        add_word(tlv_len);
        if (tlv_len > 0 && tlv_len <= PAYLOAD_MAX)
            repeat (tlv_len) frame_q.push_back(8'($urandom));
    endtask

    function automatic logic [31:0] random_tlv_type();
        case ($urandom_range(0, 3))
            0, 1:    return cfg_points_type;
            2:       return cfg_points_type ^ (32'd1 << $urandom_range(0, 31));
            default: return $urandom;
        endcase
    endfunction

    // mostly short payloads, a few longer, some zero or oversized
    function automatic logic [31:0] random_tlv_len();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return $urandom_range(32'hFFFF_FFFF, PAYLOAD_MAX + 1);
            2:       return $urandom_range(49, 200);
            default: return $urandom_range(1, 48);
        endcase
    endfunction

    // mostly whole frames with random content, plus noise and cut-off sync words
    task automatic random_traffic(input int unsigned budget, input bit allow_idle);
        int unsigned start;
        int unsigned kind;
        int unsigned ntlv;
        int unsigned pre;
        logic [7:0]  wrong;
        start = items_sent;
        while (items_sent - start < budget)
        begin
            idle_on = allow_idle && ($urandom_range(0, 3) != 0);
            kind    = $urandom_range(0, 19);
            if (kind < 14)
            begin
                ntlv = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
                start_frame(ntlv);
                repeat (ntlv) add_tlv(random_tlv_type(), random_tlv_len());
            end
            else if (kind < 17)
            begin
                repeat ($urandom_range(1, 6)) frame_q.push_back(8'($urandom));
            end
            else
            begin
                pre = $urandom_range(1, 3);
                for (int k = 0; k < pre; k++)
                    frame_q.push_back(magic_byte(k));
                wrong = 8'($urandom);
                if (wrong == magic_byte(pre))
                    wrong = ~wrong;
                frame_q.push_back(wrong);
            end
            send_bytes(1'b0);
            // noise can leave the hunt part way; break it so the next frame syncs
            while (ps_phase inside {PH_MAGIC1, PH_MAGIC2, PH_MAGIC3})
            begin
                advance_tick();
                send_item(~magic_byte(ps_phase), tick_ms);
            end
        end
        idle_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    task automatic apb_write(input logic [1:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        apply_config({idx, 2'b00}, data);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // read data taken mid access phase, on the falling edge away from the rising ones
    task automatic apb_check(input logic [1:0] idx, input logic [31:0] want);
        logic [31:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        got = prdata;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (got !== want)
            note_failure($sformatf("register %0d read expected %0h got %0h", idx, want, got));
    endtask

    task automatic check_all_regs();
        apb_check(REG_MAGIC,   cfg_magic);
        apb_check(REG_PTYPE,   cfg_points_type);
        apb_check(REG_TIMEOUT, cfg_timeout);
    endtask

    task automatic set_config(input logic [31:0] magic, input logic [31:0] ptype,
                              input logic [31:0] timeout);
        apb_write(REG_MAGIC,   magic);
        apb_write(REG_PTYPE,   ptype);
        apb_write(REG_TIMEOUT, timeout);
        check_all_regs();
        settings_used++;
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset values read back; a write to the unused index changes nothing
    task automatic test_register_access();
        check_all_regs();
        apb_write(REG_UNUSED, $urandom);
        check_all_regs();
        settings_used++;
    endtask

    // sync word: broken prefix, mismatch not rechecked, empty frame, short frame
    task automatic test_magic_hunt();
        frame_q.push_back(magic_byte(0));
        frame_q.push_back(magic_byte(1));
        frame_q.push_back(magic_byte(2));
        frame_q.push_back(~magic_byte(3));
        // repeated first byte: the second copy fails and is not taken as a new start
        frame_q.push_back(magic_byte(0));
        frame_q.push_back(magic_byte(0));
        frame_q.push_back(magic_byte(1));
        frame_q.push_back(magic_byte(2));
        frame_q.push_back(magic_byte(3));
        send_bytes(1'b0);
        // tlv count of zero ends the frame after its header
        start_frame(32'd0);
        start_frame(32'd1);
        add_tlv(cfg_points_type, POINT_BYTES);
        send_bytes(1'b0);
        wait_drain();
    endtask

    // tlv walk: full-size payload capped at the target limit, partial points,
    // fewer bytes than a point, other type, zero and oversized lengths
    task automatic test_tlv_walk();
        start_frame(32'd8);
        add_tlv(cfg_points_type, PAYLOAD_MAX);
        add_tlv(cfg_points_type, POINT_BYTES + 4);
        add_tlv(cfg_points_type, 32'd5);
        add_tlv(~cfg_points_type, 32'd12);
        add_tlv(cfg_points_type, 32'd0);
        add_tlv(cfg_points_type, PAYLOAD_MAX + 1);
        add_tlv(cfg_points_type, 32'hFFFF_FFFF);
        add_tlv(cfg_points_type, 32'd1);
        send_bytes(1'b0);
        wait_drain();
    endtask

    // update recorded at tick zero reads as never; then ticks wrap past zero
    task automatic test_tick_edges();
        start_frame(32'd1);
        add_tlv(cfg_points_type, POINT_BYTES);
        send_bytes(1'b1);
        repeat (4) frame_q.push_back(8'($urandom));
        send_bytes(1'b0);
        tick_ms = 32'hFFFF_FFE0;
        start_frame(32'd2);
        add_tlv(cfg_points_type, POINT_BYTES);
        add_tlv(cfg_points_type, 2 * POINT_BYTES);
        send_bytes(1'b0);
        wait_drain();
    endtask

    // receiver holds off while the sender keeps offering: input must stall
    task automatic test_backpressure();
        hold_req <= ~hold_req;
        random_traffic(120, 1'b0);
        wait_drain();
    endtask

    // random frames under several register settings, defaults and extremes first
    task automatic test_random_settings();
        for (int s = 0; s < 6; s++)
        begin
            case (s)
                0:       set_config(MAGIC_DEFAULT, PTYPE_DEFAULT, TIMEOUT_DEFAULT);
                1:       set_config('0, '0, '0);
                2:       set_config('1, '1, '1);
                3:       set_config($urandom, $urandom_range(0, 3), $urandom_range(1, 50));
                4:       set_config($urandom, PTYPE_DEFAULT, 32'd1);
                default: set_config($urandom, $urandom, $urandom);
            endcase
            random_traffic(ITEMS_PER_SETUP, 1'b1);
            wait_drain();
        end
    endtask

    // huge tlv count with top bit set; the parser never gets back to hunting,
    // so this runs last
    task automatic test_huge_count();
        start_frame(32'h8000_0003);
        add_tlv(cfg_points_type, 32'd0);
        add_tlv(cfg_points_type, POINT_BYTES);
        add_tlv(~cfg_points_type, 32'd7);
        add_tlv(cfg_points_type, 32'd3);
        send_bytes(1'b0);
        wait_drain();
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_register_access();
        test_magic_hunt();
        test_tlv_walk();
        test_tick_edges();
        test_backpressure();
        test_random_settings();
        test_huge_count();
        $display("covered %0d items and %0d results, %0d point updates, %0d register setups",
                 items_sent, results_checked, updates_seen, settings_used);
        $display("mismatches: %0d", mismatches);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // hang guard, far beyond the slowest correct run
    initial
    begin
        #2_000_000;
        $display("timeout with %0d results still pending", pending_results.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
